[rtl/core/spmf_pkg.sv]
`timescale 1ns / 1ps

package spmf_pkg;

  // Sizing
  localparam int LEVELS        = 8;
  localparam int LEVEL_DEPTH   = 16;
  localparam int PAYLOAD_WIDTH = 32;

  localparam int STORE_DEPTH = LEVELS * LEVEL_DEPTH;
  localparam int LVL_W       = $clog2(LEVELS);
  localparam int PTR_W       = $clog2(LEVEL_DEPTH);
  localparam int CNT_W       = $clog2(LEVEL_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int TOT_W       = $clog2(STORE_DEPTH + 1);

  // Item field widths
  localparam int OP_W       = 2;
  localparam int PRIO_W     = 3;
  localparam int WORD_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int OCC_W      = 8;
  localparam int STORE_W    = (PAYLOAD_WIDTH < WORD_W) ? PAYLOAD_WIDTH : WORD_W;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_POP   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef logic [LVL_W-1:0]   lvl_t;
  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [TOT_W-1:0]   tot_t;
  typedef logic [STORE_W-1:0] word_t;

endpackage

[rtl/core/strict_priority_multi_fifo_core.sv]
`timescale 1ns / 1ps

// Strict priority queue: one FIFO per level, higher level served first. Takes one
// push, pop or clear item per clock. Each item gives one result item. An accepted
// item sits in the input register, then moves into the result register; the payload
// RAM's registered read loads on that same edge. The input only stalls while a
// result is held back by out_tready. A push to a full level is dropped with status
// full; a pop with every level empty returns status empty. No clearing pass is
// needed after reset.
module strict_priority_multi_fifo_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [1:0] op, [4:2] priority_req, [36:5] payload, [39:37] zero
  input  logic [spmf_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] out_payload, [34:32] out_priority, [36:35] status, [44:37] occupancy,
  // [47:45] zero
  output logic [spmf_pkg::OUT_DATA_W-1:0] out_tdata
);

  // Input register
  logic                                a_valid_r;
  logic [spmf_pkg::OP_W-1:0]           a_op_r;
  logic [spmf_pkg::PRIO_W-1:0]         a_prio_r;
  spmf_pkg::word_t                     a_word_r;

  // Queue state
  spmf_pkg::ptr_t                      head_r [spmf_pkg::LEVELS];
  spmf_pkg::ptr_t                      tail_r [spmf_pkg::LEVELS];
  spmf_pkg::cnt_t                      cnt_r  [spmf_pkg::LEVELS];
  spmf_pkg::tot_t                      tot_r;
  spmf_pkg::word_t                     mem [spmf_pkg::STORE_DEPTH];

  // Result register
  logic                                b_valid_r;
  logic                                b_pop_ok_r;
  spmf_pkg::lvl_t                      b_lvl_r;
  logic [spmf_pkg::STATUS_W-1:0]       b_status_r;
  logic [spmf_pkg::OCC_W-1:0]          b_occ_r;
  spmf_pkg::word_t                     rd_q_r;

  logic                                adv;
  spmf_pkg::lvl_t                      lvl_push;
  spmf_pkg::lvl_t                      lvl_pop;
  logic                                any_full;
  logic                                found;
  logic                                push_ok;
  logic                                pop_ok;
  logic                                do_clear;
  logic [spmf_pkg::STATUS_W-1:0]       status_nxt;
  spmf_pkg::tot_t                      tot_nxt;
  spmf_pkg::addr_t                     wr_addr;
  spmf_pkg::addr_t                     rd_addr;
  spmf_pkg::word_t                     out_word;

  assign adv       = a_valid_r && (!b_valid_r || out_tready);
  assign in_tready = !a_valid_r || adv;

  // Level selection and decision
  always_comb begin
    lvl_push = (int'(a_prio_r) >= spmf_pkg::LEVELS) ? spmf_pkg::lvl_t'(spmf_pkg::LEVELS - 1)
                                                      : spmf_pkg::lvl_t'(a_prio_r);
    any_full = (cnt_r[lvl_push] == spmf_pkg::cnt_t'(spmf_pkg::LEVEL_DEPTH));
    found    = 1'b0;
    lvl_pop  = '0;
    // last hit wins, so the highest non-empty level is picked
    for (int i = 0; i < spmf_pkg::LEVELS; i++) begin
      if (cnt_r[i] != '0) begin
        found   = 1'b1;
        lvl_pop = spmf_pkg::lvl_t'(i);
      end
    end
  end

  always_comb begin
    push_ok    = 1'b0;
    pop_ok     = 1'b0;
    do_clear   = 1'b0;
    status_nxt = spmf_pkg::ST_OK;
    tot_nxt    = tot_r;
    case (a_op_r)
      spmf_pkg::OP_PUSH: begin
        if (any_full) begin
          status_nxt = spmf_pkg::ST_FULL;
        end else begin
          push_ok = 1'b1;
          tot_nxt = tot_r + 1'b1;
        end
      end
      spmf_pkg::OP_POP: begin
        if (!found) begin
          status_nxt = spmf_pkg::ST_EMPTY;
        end else begin
          pop_ok  = 1'b1;
          tot_nxt = tot_r - 1'b1;
        end
      end
      spmf_pkg::OP_CLEAR: begin
        do_clear = 1'b1;
        tot_nxt  = '0;
      end
      default: begin
      end
    endcase
  end

  assign wr_addr = spmf_pkg::addr_t'(lvl_push) * spmf_pkg::addr_t'(spmf_pkg::LEVEL_DEPTH)
                 + spmf_pkg::addr_t'(tail_r[lvl_push]);
  assign rd_addr = spmf_pkg::addr_t'(lvl_pop) * spmf_pkg::addr_t'(spmf_pkg::LEVEL_DEPTH)
                 + spmf_pkg::addr_t'(head_r[lvl_pop]);

  // Input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_tready) begin
      a_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      a_op_r   <= in_tdata[1:0];
      a_prio_r <= in_tdata[4:2];
      a_word_r <= in_tdata[5 +: spmf_pkg::STORE_W];
    end
  end

  // Level pointers and counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < spmf_pkg::LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
      tot_r <= '0;
    end else if (adv) begin
      tot_r <= tot_nxt;
      for (int i = 0; i < spmf_pkg::LEVELS; i++) begin
        if (do_clear) begin
          head_r[i] <= '0;
          tail_r[i] <= '0;
          cnt_r[i]  <= '0;
        end else if (push_ok && lvl_push == spmf_pkg::lvl_t'(i)) begin
          tail_r[i] <= (tail_r[i] == spmf_pkg::ptr_t'(spmf_pkg::LEVEL_DEPTH - 1))
                       ? '0 : tail_r[i] + 1'b1;
          cnt_r[i]  <= cnt_r[i] + 1'b1;
        end else if (pop_ok && lvl_pop == spmf_pkg::lvl_t'(i)) begin
          head_r[i] <= (head_r[i] == spmf_pkg::ptr_t'(spmf_pkg::LEVEL_DEPTH - 1))
                       ? '0 : head_r[i] + 1'b1;
          cnt_r[i]  <= cnt_r[i] - 1'b1;
        end
      end
    end
  end

  // Payload RAM: one write port, one registered read port. The read register only
  // loads on a successful pop, so it holds while the result is stalled.
  always_ff @(posedge clk) begin
    if (adv && push_ok) begin
      mem[wr_addr] <= a_word_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && pop_ok) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // Result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r <= 1'b1;
    end else if (out_tready) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_pop_ok_r <= pop_ok;
      b_lvl_r    <= pop_ok ? lvl_pop : '0;
      b_status_r <= status_nxt;
      b_occ_r    <= spmf_pkg::OCC_W'(tot_nxt);
    end
  end

  assign out_word   = b_pop_ok_r ? rd_q_r : '0;
  assign out_tvalid = b_valid_r;
  assign out_tdata  = {3'b000,
                       b_occ_r,
                       b_status_r,
                       spmf_pkg::PRIO_W'(b_lvl_r),
                       spmf_pkg::WORD_W'(out_word)};

  // Checks
  a_tot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(tot_r) <= spmf_pkg::STORE_DEPTH)
    else $error("total occupancy above capacity");

  a_empty_means_zero: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r && b_status_r == spmf_pkg::ST_EMPTY |-> b_occ_r == '0)
    else $error("empty pop reported with stored items");

  a_pop_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r && b_pop_ok_r |-> b_status_r == spmf_pkg::ST_OK)
    else $error("popped item carries error status");

  a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r && b_pop_ok_r && !out_tready |=> $stable(rd_q_r))
    else $error("read data changed under stall");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && !adv |=> a_valid_r && $stable(a_op_r))
    else $error("input register lost an item");

endmodule

[test/spmf_checker.sv]
`timescale 1ns / 1ps

module spmf_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [spmf_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [spmf_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                              mismatches,
  output int                              pending
);
  import spmf_pkg::*;

  // matches out_tdata from bit 0 up: payload, priority, status, occupancy
  typedef struct packed {
    logic [OCC_W-1:0]    occupancy;
    logic [STATUS_W-1:0] status;
    logic [PRIO_W-1:0]   prio;
    logic [WORD_W-1:0]   payload;
  } queue_result_t;

  word_t         level_fifo [LEVELS][$];
  queue_result_t expected_results [$];

  function automatic queue_result_t apply_queue_op(input logic [OP_W-1:0]   op,
                                                   input logic [PRIO_W-1:0] req_lvl,
                                                   input logic [WORD_W-1:0] word);
    queue_result_t res;
    int            lvl;
    int            hit;
    int            total;
    res   = '0;
    hit   = -1;
    total = 0;
    lvl   = (int'(req_lvl) >= LEVELS) ? LEVELS - 1 : int'(req_lvl);
    case (op)
      OP_PUSH: begin
        if (level_fifo[lvl].size() >= LEVEL_DEPTH)
          res.status = ST_FULL;
        else
          level_fifo[lvl].push_back(word_t'(word));
      end
      OP_POP: begin
        for (int lv = LEVELS - 1; lv >= 0; lv--) begin
          if (hit < 0 && level_fifo[lv].size() != 0)
            hit = lv;
        end
        if (hit < 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.payload = WORD_W'(level_fifo[hit].pop_front());
          res.prio    = PRIO_W'(hit);
        end
      end
      OP_CLEAR: begin
        for (int lv = 0; lv < LEVELS; lv++)
          level_fifo[lv].delete();
      end
      default: ;  // unused code: no-op
    endcase
    for (int lv = 0; lv < LEVELS; lv++)
      total += level_fifo[lv].size();
    res.occupancy = OCC_W'(total);
    return res;
  endfunction

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    queue_result_t got;
    queue_result_t want;
    if (!rst_n) begin
      for (int lv = 0; lv < LEVELS; lv++)
        level_fifo[lv].delete();
      expected_results.delete();
    end else begin
      if (in_tvalid && in_tready)
        expected_results.push_back(apply_queue_op(in_tdata[OP_W-1:0],
                                                  in_tdata[OP_W +: PRIO_W],
                                                  in_tdata[OP_W+PRIO_W +: WORD_W]));
      if (out_tvalid && out_tready) begin
        got = queue_result_t'(out_tdata[$bits(queue_result_t)-1:0]);
        if (expected_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected item payload=%h prio=%0d status=%0d occ=%0d",
                     $time, got.payload, got.prio, got.status, got.occupancy);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (got.payload !== want.payload || got.prio !== want.prio ||
              got.status !== want.status || got.occupancy !== want.occupancy) begin
            if (mismatches < 10) begin
              $display("%0t: mismatch expected payload=%h prio=%0d status=%0d occ=%0d",
                       $time, want.payload, want.prio, want.status, want.occupancy);
              $display("%0t:          actual   payload=%h prio=%0d status=%0d occ=%0d",
                       $time, got.payload, got.prio, got.status, got.occupancy);
            end
            mismatches++;
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

[test/strict_priority_multi_fifo_core_tb.sv]
`timescale 1ns / 1ps

module strict_priority_multi_fifo_core_tb;
  import spmf_pkg::*;

  localparam logic [OP_W-1:0] OP_NOP = 2'd3;  // unused code

  localparam int QUEUE_OPS      = 1600;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIXED, SEG_SPREAD} seg_kind_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  int mismatches;
  int pending;
  int idle_cycles;
  bit tx_gaps_on;
  bit rx_gaps_on;
  bit rx_hold_req;

  strict_priority_multi_fifo_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  spmf_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: random stall per item, plus one long hold on request
  initial begin : result_sink
    int gap;
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (rx_hold_req) begin
        out_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        rx_hold_req = 1'b0;
      end
      gap = rx_gaps_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_op(input logic [OP_W-1:0] op, input logic [PRIO_W-1:0] lvl,
                         input logic [WORD_W-1:0] word);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W - OP_W - PRIO_W - WORD_W){1'b0}}, word, lvl, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // stop offering, so the last item is not sent again while results drain
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    seg_kind_t         kind;
    int                sent;
    int                seg_idx;
    int                seg_len;
    int                push_pct;
    int                clear_pct;
    int                roll;
    logic [PRIO_W-1:0] focus_a;
    logic [PRIO_W-1:0] focus_b;
    logic [PRIO_W-1:0] lvl;
    logic [OP_W-1:0]   op;

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    idle_cycles = 0;
    tx_gaps_on  = 1'b1;
    rx_gaps_on  = 1'b1;
    rx_hold_req = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty pop, no-op, priority order, clear
    send_op(OP_POP, 3'd0, 32'hDEAD_BEEF);
    send_op(OP_NOP, 3'd7, 32'hFFFF_FFFF);
    send_op(OP_PUSH, 3'd0, 32'h0000_0000);
    send_op(OP_PUSH, 3'd7, 32'hFFFF_FFFF);
    send_op(OP_PUSH, 3'd3, 32'hA5A5_5A5A);
    send_op(OP_PUSH, 3'd7, 32'h5555_AAAA);
    send_op(OP_POP, 3'd5, 32'h1234_5678);
    send_op(OP_POP, 3'd0, 32'h0);
    send_op(OP_POP, 3'd0, 32'h0);
    send_op(OP_POP, 3'd0, 32'h0);
    send_op(OP_POP, 3'd0, 32'h0);
    send_op(OP_PUSH, 3'd2, 32'hAAAA_5555);
    send_op(OP_PUSH, 3'd6, 32'h0F0F_F0F0);
    send_op(OP_CLEAR, 3'd4, 32'hCAFE_F00D);
    send_op(OP_POP, 3'd0, 32'h0);
    send_op(OP_NOP, 3'd0, 32'h0);
    wait_drained();

    sent    = 0;
    seg_idx = 0;
    while (sent < QUEUE_OPS) begin
      kind = seg_kind_t'($urandom_range(0, 3));
      if (seg_idx == 6) begin
        kind        = SEG_FILL;
        rx_hold_req = 1'b1;  // sender keeps offering while the sink holds off
      end
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_gaps_on = ($urandom_range(0, 3) != 0);
      focus_a    = PRIO_W'($urandom_range(0, 7));
      focus_b    = PRIO_W'($urandom_range(0, 7));
      case (kind)
        SEG_FILL:   begin push_pct = 85; clear_pct = 0; seg_len = $urandom_range(20, 60);  end
        SEG_DRAIN:  begin push_pct = 20; clear_pct = 2; seg_len = $urandom_range(10, 60);  end
        SEG_MIXED:  begin push_pct = 50; clear_pct = 2; seg_len = $urandom_range(10, 60);  end
        default:    begin push_pct = 85; clear_pct = 0; seg_len = $urandom_range(60, 180); end
      endcase
      for (int i = 0; i < seg_len; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < clear_pct)
          op = OP_CLEAR;
        else if (roll < clear_pct + 2)
          op = OP_NOP;
        else if (roll < push_pct)
          op = OP_PUSH;
        else
          op = OP_POP;
        if (kind == SEG_FILL)
          lvl = $urandom_range(0, 1) ? focus_a : focus_b;
        else
          lvl = PRIO_W'($urandom_range(0, 7));
        send_op(op, lvl, $urandom);
      end
      sent += seg_len;
      seg_idx++;
      if (seg_idx % 4 == 0)
        wait_drained();
    end

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
